// ===== hw/rtl/sca_pkg.sv =====
// shared types, codes and defaults for the slab class allocator
package sca_pkg;

  localparam int NUM_SLABS_DEF  = 64;
  localparam int SLAB_BYTES_DEF = 4194304;
  localparam int FREE_DEPTH_DEF = 4096;

  localparam int HANDLE_W = 28;
  localparam int SIZE_W   = 23;
  localparam int SLAB_W   = 6;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  localparam logic [SIZE_W-1:0] ALLOC_SIZE_RST = SIZE_W'(64);

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNOWNED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SLAB_W-1:0]   slab_index;
    logic [HANDLE_W-1:0] handle;
  } command_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle_out;
  } result_t;

endpackage

// ===== hw/rtl/slab_class_allocator.sv =====
// Each command is taken at a clock edge where start is high and busy is low; its result is on
// result for exactly one cycle, marked by done, after the memory reads and the execute state,
// and a new command can be taken in that same cycle, so the block handles one command at a time.
// The freed-chunk, spare-slab and ownership memories are read at the transfer, and the execute
// state then updates them. After reset the ownership memory is cleared one entry a cycle, with
// busy high until all NUM_SLABS entries are clear; alloc_size writes are taken at any time.
// SLAB_BYTES must be a power of two.
module slab_class_allocator
  import sca_pkg::*;
#(
  parameter int NUM_SLABS  = NUM_SLABS_DEF,
  parameter int SLAB_BYTES = SLAB_BYTES_DEF,
  parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  command_t          command,
  output logic              done,
  output result_t           result,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int SLAB_SHIFT = $clog2(SLAB_BYTES);
  localparam int SNUM_W     = HANDLE_W - SLAB_SHIFT;
  localparam int OAW        = $clog2(NUM_SLABS);
  localparam int SCW        = $clog2(NUM_SLABS + 1);
  localparam int FAW        = $clog2(FREE_DEPTH);
  localparam int FCW        = $clog2(FREE_DEPTH + 1);
  localparam logic [SIZE_W:0] SLAB_LIMIT = (SIZE_W + 1)'(SLAB_BYTES);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]          state, state_next;
  logic [OAW-1:0]      clr_idx;

  logic [SIZE_W-1:0]   alloc_size;
  logic [FCW-1:0]      freed_count, freed_count_next;
  logic [SCW-1:0]      spare_count, spare_count_next;
  logic [SLAB_W-1:0]   carve_slab, carve_slab_next;
  logic                carve_valid, carve_valid_next;
  logic [SIZE_W-1:0]   carve_offset, carve_offset_next;
  logic                may_allocate, may_allocate_next;

  // memories
  logic [HANDLE_W-1:0] freed_mem [FREE_DEPTH];
  logic [SLAB_W-1:0]   spare_mem [NUM_SLABS];
  logic                owned_mem [NUM_SLABS];

  logic [HANDLE_W-1:0] freed_rd;
  logic [SLAB_W-1:0]   spare_rd;
  logic                owned_rd;

  // command held for the execute cycle
  command_t            cmd_q;
  logic                oob_q;

  logic                accept;
  logic [SNUM_W-1:0]   in_slab;
  logic                in_oob;
  logic [FCW-1:0]      freed_top;
  logic [SCW-1:0]      spare_top;

  logic                freed_we, spare_we, owned_we;
  logic [SIZE_W:0]     carve_sum;
  logic                can_carve, fresh_fit;
  result_t             res_next;
  logic                done_next;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign in_slab   = command.handle[HANDLE_W-1:SLAB_SHIFT];
  assign in_oob    = (command.cmd == CMD_ADD) ? (32'(command.slab_index) >= 32'(NUM_SLABS))
                                              : (32'(in_slab) >= 32'(NUM_SLABS));
  assign freed_top = freed_count - FCW'(1);
  assign spare_top = spare_count - SCW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      freed_rd <= freed_mem[freed_top[FAW-1:0]];
      spare_rd <= spare_mem[spare_top[OAW-1:0]];
      owned_rd <= owned_mem[OAW'(in_slab)];
      cmd_q    <= command;
      oob_q    <= in_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (freed_we) begin
      freed_mem[freed_count[FAW-1:0]] <= cmd_q.handle;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_we) begin
      spare_mem[spare_count[OAW-1:0]] <= cmd_q.slab_index;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      owned_mem[clr_idx] <= 1'b0;
    end else if (owned_we) begin
      owned_mem[OAW'(cmd_q.slab_index)] <= 1'b1;
    end
  end

  assign carve_sum = {1'b0, carve_offset} + {1'b0, alloc_size};
  assign can_carve = carve_valid && (carve_sum <= SLAB_LIMIT);
  assign fresh_fit = ({1'b0, alloc_size} <= SLAB_LIMIT);

  always_comb begin
    freed_count_next  = freed_count;
    spare_count_next  = spare_count;
    carve_slab_next   = carve_slab;
    carve_valid_next  = carve_valid;
    carve_offset_next = carve_offset;
    may_allocate_next = may_allocate;
    freed_we          = 1'b0;
    spare_we          = 1'b0;
    owned_we          = 1'b0;
    res_next          = '{status: STAT_OK, handle_out: '0};
    done_next         = (state == S_EXEC);
    if (state == S_EXEC) begin
      case (cmd_q.cmd)
        CMD_ADD: begin
          if (oob_q) begin
            res_next.status = STAT_UNOWNED;
          end else if (spare_count == SCW'(NUM_SLABS)) begin
            res_next.status = STAT_OVERFLOW;
          end else begin
            may_allocate_next = 1'b1;
            owned_we          = 1'b1;
            spare_we          = 1'b1;
            spare_count_next  = spare_count + SCW'(1);
          end
        end
        CMD_ALLOC: begin
          if (!may_allocate) begin
            res_next.status = STAT_OOM;
          end else if (freed_count == '0 && spare_count == '0 && !can_carve) begin
            may_allocate_next = 1'b0;
            res_next.status   = STAT_OOM;
          end else if (freed_count != '0) begin
            freed_count_next    = freed_top;
            res_next.handle_out = freed_rd;
          end else if (can_carve) begin
            res_next.handle_out = (HANDLE_W'(carve_slab) << SLAB_SHIFT) + HANDLE_W'(carve_offset);
            carve_offset_next   = carve_sum[SIZE_W-1:0];
          end else begin
            // take a spare slab and carve from its start
            spare_count_next  = spare_top;
            carve_slab_next   = spare_rd;
            carve_valid_next  = 1'b1;
            carve_offset_next = '0;
            if (fresh_fit) begin
              res_next.handle_out = HANDLE_W'(spare_rd) << SLAB_SHIFT;
              carve_offset_next   = alloc_size;
            end else begin
              res_next.status = STAT_OOM;
            end
          end
        end
        CMD_FREE: begin
          if (oob_q || !owned_rd) begin
            res_next.status = STAT_UNOWNED;
          end else if (freed_count == FCW'(FREE_DEPTH)) begin
            res_next.status = STAT_OVERFLOW;
          end else begin
            freed_we          = 1'b1;
            freed_count_next  = freed_count + FCW'(1);
            may_allocate_next = 1'b1;
          end
        end
        default: begin
          res_next.status = STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == OAW'(NUM_SLABS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      alloc_size   <= ALLOC_SIZE_RST;
      freed_count  <= '0;
      spare_count  <= '0;
      carve_slab   <= '0;
      carve_valid  <= 1'b0;
      carve_offset <= '0;
      may_allocate <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + OAW'(1);
      end
      if (cfg_we) begin
        alloc_size <= cfg_data;
      end
      freed_count  <= freed_count_next;
      spare_count  <= spare_count_next;
      carve_slab   <= carve_slab_next;
      carve_valid  <= carve_valid_next;
      carve_offset <= carve_offset_next;
      may_allocate <= may_allocate_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

// ===== hw/rtl/sca_checker.sv =====
// port-level checks for the slab class allocator, bound to the top level
module sca_checker
  import sca_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // a transfer occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  // every transfer produces its result strobe after the execute state
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("missing result strobe after command transfer");

  // results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

  // a failed command hands out no address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STAT_OK |-> result.handle_out == '0)
    else $error("nonzero handle on failed command");

endmodule

bind slab_class_allocator sca_checker u_sca_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== tb/slab_class_allocator_tb.sv =====
// self-checking testbench for the slab class allocator: predicted results checked at the result port
`timescale 1ns / 100ps

module slab_class_allocator_tb
  import sca_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam int LIVE_CAP = 512;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  command_t command = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  slab_class_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted allocator state
  logic [HANDLE_W-1:0] freed_stack [FREE_DEPTH_DEF];
  int                  freed_top = 0;
  logic [SLAB_W-1:0]   spare_stack [NUM_SLABS_DEF];
  int                  spare_top = 0;
  bit                  owned [NUM_SLABS_DEF];
  logic [SLAB_W-1:0]   cur_slab = '0;
  bit                  cur_valid = 1'b0;
  logic [SIZE_W-1:0]   cur_offset = '0;
  bit                  alloc_ok = 1'b0;
  logic [SIZE_W-1:0]   chunk_size = ALLOC_SIZE_RST;

  command_t            cmd_backlog [$];
  result_t             awaited_results [$];
  logic [HANDLE_W-1:0] live_handles [$];
  int                  fail_count = 0;
  bit                  gaps_on = 1'b1;
  int                  gap_left = 0;

  function automatic bit carve_fits();
    return cur_valid && ({9'd0, cur_offset} + {9'd0, chunk_size} <= 32'(SLAB_BYTES_DEF));
  endfunction

  function automatic logic [HANDLE_W-1:0] carve_next();
    logic [31:0] addr;
    addr = 32'(cur_slab) * 32'(SLAB_BYTES_DEF) + 32'(cur_offset);
    cur_offset = cur_offset + chunk_size;
    return addr[HANDLE_W-1:0];
  endfunction

  function automatic result_t predict_allocation(command_t c);
    result_t r;
    logic [31:0] fslab;
    r.status = STAT_OK;
    r.handle_out = '0;
    case (c.cmd)
      CMD_ADD: begin
        if (int'(c.slab_index) >= NUM_SLABS_DEF) begin
          r.status = STAT_UNOWNED;
        end else if (spare_top >= NUM_SLABS_DEF) begin
          r.status = STAT_OVERFLOW;
        end else begin
          alloc_ok = 1'b1;
          owned[c.slab_index] = 1'b1;
          spare_stack[spare_top] = c.slab_index;
          spare_top++;
        end
      end
      CMD_ALLOC: begin
        if (!alloc_ok) begin
          r.status = STAT_OOM;
        end else if (freed_top == 0 && spare_top == 0 && !carve_fits()) begin
          alloc_ok = 1'b0;
          r.status = STAT_OOM;
        end else if (freed_top > 0) begin
          freed_top--;
          r.handle_out = freed_stack[freed_top];
        end else if (carve_fits()) begin
          r.handle_out = carve_next();
        end else begin
          // current slab used up: take the most recent spare slab
          spare_top--;
          cur_slab = spare_stack[spare_top];
          cur_valid = 1'b1;
          cur_offset = '0;
          if (carve_fits()) r.handle_out = carve_next();
          else r.status = STAT_OOM;
        end
        if (r.status == STAT_OK && live_handles.size() < LIVE_CAP)
          live_handles = {live_handles, r.handle_out};
      end
      CMD_FREE: begin
        fslab = 32'(c.handle) / 32'(SLAB_BYTES_DEF);
        if (fslab >= 32'(NUM_SLABS_DEF) || !owned[fslab]) begin
          r.status = STAT_UNOWNED;
        end else if (freed_top >= FREE_DEPTH_DEF) begin
          r.status = STAT_OVERFLOW;
        end else begin
          freed_stack[freed_top] = c.handle;
          freed_top++;
          alloc_ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] owned_handle(logic [HANDLE_W-1:0] fallback);
    int slabs [$];
    for (int s = 0; s < NUM_SLABS_DEF; s++) if (owned[s]) slabs = {slabs, s};
    if (slabs.size() == 0) return fallback;
    return {SLAB_W'(slabs[$urandom_range(0, slabs.size() - 1)]),
            (HANDLE_W - SLAB_W)'($urandom)};
  endfunction

  function automatic void issue(logic [CMD_W-1:0] op, logic [SLAB_W-1:0] s,
                                logic [HANDLE_W-1:0] h);
    command_t c;
    c.cmd = op;
    c.slab_index = s;
    c.handle = h;
    cmd_backlog = {cmd_backlog, c};
  endfunction

  function automatic command_t random_command();
    command_t c;
    int roll;
    int pick;
    c.cmd = CMD_ALLOC;
    c.slab_index = SLAB_W'($urandom);
    c.handle = HANDLE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      c.cmd = CMD_ADD;
    end else if (roll < 55) begin
      c.cmd = CMD_ALLOC;
    end else if (roll < 93) begin
      c.cmd = CMD_FREE;
      pick = $urandom_range(0, 99);
      // half the time give back a handed-out chunk, else an owned-slab address or any address
      if (pick < 50 && live_handles.size() > 0) begin
        pick = $urandom_range(0, live_handles.size() - 1);
        c.handle = live_handles[pick];
        live_handles.delete(pick);
      end else if (pick < 85) begin
        c.handle = owned_handle(c.handle);
      end
    end else begin
      c.cmd = CMD_UNUSED;
    end
    return c;
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_backlog.size() != 0 || start || awaited_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_alloc_size(logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    chunk_size = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: one command per transfer, random idle bursts while gaps_on
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 4);
      end else begin
        start <= 1'b1;
        command <= cmd_backlog.pop_front();
      end
    end
  end

  // monitor: predict on each transfer, check each done strobe
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d handle %h",
                   $time, result.status, result.handle_out);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, result.status);
            fail_count++;
          end
          if (result.handle_out !== want.handle_out) begin
            $display("%0t: handle_out expected %h, got %h", $time, want.handle_out,
                     result.handle_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) awaited_results = {awaited_results, predict_allocation(command)};
    end
  end

  initial begin
    int n;
    logic [SIZE_W-1:0] size_pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // nothing owned yet, unused command, free of an unowned slab
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_UNUSED, '0, '0);
    issue(CMD_FREE, '1, '1);
    issue(CMD_ADD, 6'd0, '0);
    issue(CMD_ADD, 6'd63, '1);
    issue(CMD_ALLOC, '1, '0);
    issue(CMD_ALLOC, '0, '1);
    issue(CMD_FREE, '0, {6'd63, 22'd64});
    issue(CMD_ALLOC, '0, '0);
    // misaligned free, then the same handle again
    issue(CMD_FREE, '0, '1);
    issue(CMD_FREE, '0, '1);
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_ADD, 6'd63, '0);
    issue(CMD_FREE, '0, '0);
    issue(CMD_FREE, '0, {6'd5, 22'h2AAAAA});
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_UNUSED, '1, '1);

    // one chunk per slab: drain spares until nothing is left
    wait_idle();
    write_alloc_size(SIZE_W'(SLAB_BYTES_DEF));
    repeat (4) issue(CMD_ALLOC, '0, '0);
    issue(CMD_ADD, 6'd7, '0);
    issue(CMD_ALLOC, '0, '0);

    // chunk larger than a slab
    wait_idle();
    write_alloc_size(SIZE_MAX);
    issue(CMD_ADD, 6'd9, '0);
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_ALLOC, '0, '0);

    // zero size hands out the same address twice
    wait_idle();
    write_alloc_size('0);
    issue(CMD_ADD, 6'd10, '0);
    issue(CMD_ALLOC, '0, '0);
    issue(CMD_ALLOC, '0, '0);

    // fill the spare stack past its depth
    wait_idle();
    write_alloc_size(SIZE_W'(8));
    n = NUM_SLABS_DEF - spare_top + 2;
    for (int k = 0; k < n; k++) issue(CMD_ADD, SLAB_W'($urandom), HANDLE_W'($urandom));

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: size_pick = SIZE_W'(SLAB_BYTES_DEF);
        1: size_pick = SIZE_W'($urandom_range(1, SLAB_BYTES_DEF / 8) * 8);
        2: size_pick = ALLOC_SIZE_RST;
        default: size_pick = SIZE_W'($urandom_range(8, SLAB_BYTES_DEF));
      endcase
      write_alloc_size(size_pick);
      if (p == 3) gaps_on = 1'b0;
      for (int k = 0; k < 185; k++) begin
        while (cmd_backlog.size() > 4) begin
          @(posedge clk);
          #1;
        end
        cmd_backlog = {cmd_backlog, random_command()};
      end
    end

    // allocate six chunks, then free two addresses in owned slabs
    wait_idle();
    repeat (6) issue(CMD_ALLOC, '0, '0);
    issue(CMD_FREE, '0, owned_handle('0));
    issue(CMD_FREE, '0, owned_handle('0));

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
